### hdl/eoq_pkg.sv
// Shared types, codes and constants for the elevator order queue.
`timescale 1ns / 1ps
package eoq_pkg;

  // Number of served floors: decides lamp bits and which floors erase clears
  localparam int NUM_FLOORS = 4;

  // Transaction function codes
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_ERASE = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // Call type that matches any other type at the same floor
  localparam logic [1:0] CALL_CAB = 2'd2;

  // Operations sent to every cell of the chain
  localparam logic [2:0] CELL_HOLD  = 3'd0;
  localparam logic [2:0] CELL_PUSH  = 3'd1;
  localparam logic [2:0] CELL_CLEAR = 3'd2;
  localparam logic [2:0] CELL_ERASE = 3'd3;
  localparam logic [2:0] CELL_SHIFT = 3'd4;

  // One stored order
  typedef struct packed {
    logic       valid;
    logic [1:0] floor;
    logic [1:0] call_type;
  } eoq_entry_t;

  // Command broadcast to the cells
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] floor;
    logic [1:0] call_type;
  } eoq_ctl_t;

  // Lamp bit for one floor, none for floors beyond the building
  function automatic logic [3:0] lamp_bit(input logic [1:0] fl);
    logic [3:0] m;
    m = '0;
    if (int'(fl) < NUM_FLOORS) m = 4'(1) << fl;
    return m;
  endfunction

  // Lamp bits of every served floor
  function automatic logic [3:0] lamp_all();
    logic [3:0] m;
    m = '0;
    for (int f = 0; f < 4; f++) begin
      if (f < NUM_FLOORS) m[f] = 1'b1;
    end
    return m;
  endfunction

endpackage

### hdl/eoq_in_if.sv
// Input channel of the order queue: command transaction with handshake.
`timescale 1ns / 1ps
interface eoq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] floor;
  logic [1:0] call_type;
  logic       car_moving;

  modport source(output valid, func, floor, call_type, car_moving, input ready);
  modport sink(input valid, func, floor, call_type, car_moving, output ready);
endinterface

### hdl/eoq_out_if.sv
// Result channel of the order queue: head and status transaction with handshake.
`timescale 1ns / 1ps
interface eoq_out_if;
  logic       valid;
  logic       ready;
  logic       head_vacant;
  logic [1:0] head_floor;
  logic [1:0] head_call_type;
  logic       order_accepted;
  logic [3:0] lamp_clear_mask;

  modport source(output valid, head_vacant, head_floor, head_call_type, order_accepted,
                 lamp_clear_mask, input ready);
  modport sink(input valid, head_vacant, head_floor, head_call_type, order_accepted,
               lamp_clear_mask, output ready);
endinterface

### hdl/eoq_cell.sv
// One queue slot: holds an order, matches pushes, clears, and shifts from its neighbor.
`timescale 1ns / 1ps
module eoq_cell
  import eoq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  eoq_ctl_t   ctl,
  input  logic       hole_in,     // an empty slot exists ahead of this one
  input  eoq_entry_t nbr_in,      // content of the next slot toward the tail
  output logic       hole_out,
  output eoq_entry_t entry,
  output logic       floor_hit,   // valid and same floor
  output logic       full_hit,    // valid, same floor, same type or cab
  output logic       pend         // valid with a hole ahead: compaction not done
);

  eoq_entry_t entry_r, entry_nxt;

  assign entry     = entry_r;
  assign hole_out  = hole_in | ~entry_r.valid;
  assign floor_hit = entry_r.valid && (entry_r.floor == ctl.floor);
  assign full_hit  = floor_hit &&
                     ((entry_r.call_type == ctl.call_type) || (entry_r.call_type == CALL_CAB));
  assign pend      = entry_r.valid & hole_in;

  // Next slot content per broadcast command
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_PUSH: begin
        // only the first empty slot takes the order
        if (!entry_r.valid && !hole_in) begin
          entry_nxt.valid     = 1'b1;
          entry_nxt.floor     = ctl.floor;
          entry_nxt.call_type = ctl.call_type;
        end
      end
      CELL_CLEAR: begin
        if (floor_hit) entry_nxt.valid = 1'b0;
      end
      CELL_ERASE: begin
        if (int'(entry_r.floor) < NUM_FLOORS) entry_nxt.valid = 1'b0;
      end
      CELL_SHIFT: begin
        // slots at or behind the first hole move up by one
        if (hole_out) entry_nxt = nbr_in;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### hdl/elevator_order_queue.sv
// Elevator order queue: a chain of order slots with duplicate drop and compaction.
//
// Usage:
//   in_if  (sink)  : one command transaction (push, clear floor, erase all, query).
//   out_if (source): exactly one result transaction per command: head order,
//                    empty flag, push acceptance and lamp-clear mask.
//   A command is taken only while the block is idle; the result sits in an
//   output register, so the next command is taken while it waits.
// Sequence:
//   Push, or clear/erase with the car between floors: the command is applied
//   to all slots in the accept cycle; the result then loads from the done
//   state once the output is free.
//   Clear/erase with the car at a floor, and query: the slot chain closes one
//   hole per cycle until no hole is left ahead of the last stored order (at
//   most DEPTH - 1 such holes); the result then loads from the done state.
// Reset (rst_n low, synchronous): all slots empty, no result pending.
// Stall: while out_if.ready is low the result is held; a finished command
//   then waits before loading, and no further command is taken.
`timescale 1ns / 1ps
module elevator_order_queue
  import eoq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  eoq_in_if.sink    in_if,
  eoq_out_if.source out_if
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COMPACT = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       cmp_r, cmp_nxt;
  logic       acc_r, acc_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_empty_r;
  logic [1:0] out_floor_r;
  logic [1:0] out_type_r;
  logic       out_acc_r;
  logic [3:0] out_mask_r;

  eoq_ctl_t   ctl;
  eoq_entry_t ent [DEPTH];
  logic [DEPTH:0] hole;
  logic [DEPTH-1:0] floor_hit, full_hit, pend;

  logic in_fire, dup, need_shift, out_free, load;

  // Slot chain
  assign hole[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    eoq_entry_t nbr;
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    eoq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .hole_in  (hole[i]),
      .nbr_in   (nbr),
      .hole_out (hole[i+1]),
      .entry    (ent[i]),
      .floor_hit(floor_hit[i]),
      .full_hit (full_hit[i]),
      .pend     (pend[i])
    );
  end

  // Head matches on floor alone, other slots on floor with equal type or a cab entry
  assign dup        = floor_hit[0] | (|full_hit[DEPTH-1:1]);
  assign need_shift = |pend;
  assign in_fire    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_if.ready;
  assign load       = (state_r == ST_DONE) && out_free;

  // Command to the chain
  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.floor     = in_if.floor;
    ctl.call_type = in_if.call_type;
    if (in_fire) begin
      case (in_if.func)
        FUNC_PUSH:  ctl.op = dup ? CELL_HOLD : CELL_PUSH;
        FUNC_CLEAR: ctl.op = CELL_CLEAR;
        FUNC_ERASE: ctl.op = CELL_ERASE;
        default:    ctl.op = CELL_HOLD;
      endcase
    end else if (state_r == ST_COMPACT && need_shift) begin
      ctl.op = CELL_SHIFT;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmp_nxt       = cmp_r;
    acc_nxt       = acc_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt  = 1'b0;
          mask_nxt = '0;
          cmp_nxt  = 1'b0;
          case (in_if.func)
            FUNC_PUSH:  acc_nxt = !dup && hole[DEPTH];
            FUNC_CLEAR: begin
              mask_nxt = lamp_bit(in_if.floor);
              cmp_nxt  = !in_if.car_moving;
            end
            FUNC_ERASE: begin
              mask_nxt = lamp_all();
              cmp_nxt  = !in_if.car_moving;
            end
            default:    cmp_nxt = 1'b1;
          endcase
          state_nxt = cmp_nxt ? ST_COMPACT : ST_DONE;
        end
      end
      ST_COMPACT: begin
        if (!need_shift) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cmp_r       <= 1'b0;
      acc_r       <= 1'b0;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_r       <= cmp_nxt;
      acc_r       <= acc_nxt;
      mask_r      <= mask_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_empty_r <= !ent[0].valid;
      out_floor_r <= ent[0].valid ? ent[0].floor : 2'd0;
      out_type_r  <= ent[0].valid ? ent[0].call_type : 2'd0;
      out_acc_r   <= acc_r;
      out_mask_r  <= mask_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.head_vacant     = out_empty_r;
  assign out_if.head_floor      = out_floor_r;
  assign out_if.head_call_type  = out_type_r;
  assign out_if.order_accepted  = out_acc_r;
  assign out_if.lamp_clear_mask = out_mask_r;

  // Checks
  a_compact_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && cmp_r) |-> !need_shift)
    else $error("result loaded with holes left in the queue");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("command taken without work in flight");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_floor_r == 2'd0 && out_type_r == 2'd0))
    else $error("empty queue reports a head order");

  a_acc_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_acc_r && (out_mask_r != 4'd0)))
    else $error("push acceptance and lamp mask in one result");

endmodule

### tb/sv/elevator_order_queue_tb.sv
// Self-checking order queue testbench: directed and random commands against a predictor.
`timescale 1ns / 1ps
module elevator_order_queue_tb
  import eoq_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_CMDS = 1750;
  // Drain time after the last result: a full compaction plus margin
  localparam int TAIL_CYCLES = 40;

  // Call type codes besides cab; type 3 is legal on the wire and never acts as cab
  localparam logic [1:0] CALL_UP   = 2'd0;
  localparam logic [1:0] CALL_DOWN = 2'd1;
  localparam logic [1:0] CALL_ODD  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] floor;
    logic [1:0] call_type;
    logic       car_moving;
  } order_cmd_t;

  typedef struct packed {
    logic       head_vacant;
    logic [1:0] head_floor;
    logic [1:0] head_call_type;
    logic       order_accepted;
    logic [3:0] lamp_clear_mask;
  } queue_report_t;

  logic clk;
  logic rst_n;

  eoq_in_if  in_if ();
  eoq_out_if out_if ();

  elevator_order_queue #(.DEPTH(SLOTS)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  order_cmd_t    queued_cmds[$];
  queue_report_t expected_reports[$];
  eoq_entry_t    slots[SLOTS] = '{default: '0};
  int            errors = 0;
  int            cycles = 0;
  int            in_wait = 0;
  int            out_stall = 0;
  bit            in_calm = 0;
  bit            out_calm = 0;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Close holes, keeping the order of stored calls
  function automatic void squeeze_slots();
    eoq_entry_t packed_q[SLOTS];
    int w;
    w = 0;
    for (int i = 0; i < SLOTS; i++) packed_q[i] = '0;
    for (int r = 0; r < SLOTS; r++) begin
      if (slots[r].valid) begin
        packed_q[w] = slots[r];
        w++;
      end
    end
    slots = packed_q;
  endfunction

  // Drop all calls at one floor, compacting if not between floors; returns its lamp bit
  function automatic logic [3:0] empty_floor(logic [1:0] fl, logic between);
    for (int i = 0; i < SLOTS; i++) begin
      if (slots[i].valid && slots[i].floor == fl) slots[i] = '0;
    end
    if (!between) squeeze_slots();
    if (int'(fl) < NUM_FLOORS) return 4'b0001 << fl;
    return 4'b0000;
  endfunction

  // Head matches on floor alone; others on floor with equal type or a cab entry
  function automatic bit already_called(logic [1:0] fl, logic [1:0] ty);
    if (slots[0].valid && slots[0].floor == fl) return 1'b1;
    for (int i = 1; i < SLOTS; i++) begin
      if (slots[i].valid && slots[i].floor == fl &&
          (slots[i].call_type == ty || slots[i].call_type == CALL_CAB)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one command to the predicted queue and build its report
  function automatic queue_report_t predict_report(order_cmd_t c);
    queue_report_t rep;
    rep = '0;
    case (c.func)
      FUNC_PUSH: begin
        if (!already_called(c.floor, c.call_type)) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slots[i].valid) begin
              slots[i].valid     = 1'b1;
              slots[i].floor     = c.floor;
              slots[i].call_type = c.call_type;
              rep.order_accepted = 1'b1;
              break;
            end
          end
        end
      end
      FUNC_CLEAR: rep.lamp_clear_mask = empty_floor(c.floor, c.car_moving);
      FUNC_ERASE: begin
        for (int f = 0; f < NUM_FLOORS; f++)
          rep.lamp_clear_mask |= empty_floor(2'(f), c.car_moving);
      end
      FUNC_QUERY: squeeze_slots();
      default: ;
    endcase
    rep.head_vacant = !slots[0].valid;
    if (slots[0].valid) begin
      rep.head_floor     = slots[0].floor;
      rep.head_call_type = slots[0].call_type;
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_cmd(logic [1:0] func, logic [1:0] fl, logic [1:0] ty, logic between);
    order_cmd_t c;
    c.func       = func;
    c.floor      = fl;
    c.call_type  = ty;
    c.car_moving = between;
    queued_cmds.push_back(c);
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Cycle count, idle phases and timeout
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) begin
      in_calm  <= ($urandom_range(0, 3) == 0);
      out_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("elevator_order_queue_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands, predicts each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    order_cmd_t c;
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.func       <= FUNC_QUERY;
      in_if.floor      <= 2'd0;
      in_if.call_type  <= CALL_UP;
      in_if.car_moving <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        c.func       = in_if.func;
        c.floor      = in_if.floor;
        c.call_type  = in_if.call_type;
        c.car_moving = in_if.car_moving;
        expected_reports.push_back(predict_report(c));
        in_wait = idle_len(in_calm);
      end
      // Channel is free once nothing is held
      if (!in_if.valid || in_if.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_if.valid <= 1'b0;
        end else if (queued_cmds.size() > 0) begin
          c = queued_cmds.pop_front();
          in_if.func       <= c.func;
          in_if.floor      <= c.floor;
          in_if.call_type  <= c.call_type;
          in_if.car_moving <= c.car_moving;
          in_if.valid      <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, checks each result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_report_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with no command outstanding");
          errors++;
        end else begin
          exp_r = expected_reports.pop_front();
          compare_field("head_vacant", int'(exp_r.head_vacant), int'(out_if.head_vacant));
          compare_field("head_floor", int'(exp_r.head_floor), int'(out_if.head_floor));
          compare_field("head_call_type", int'(exp_r.head_call_type),
                        int'(out_if.head_call_type));
          compare_field("order_accepted", int'(exp_r.order_accepted),
                        int'(out_if.order_accepted));
          compare_field("lamp_clear_mask", int'(exp_r.lamp_clear_mask),
                        int'(out_if.lamp_clear_mask));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_stall = idle_len(out_calm);
        if (out_stall > 0) begin
          out_stall--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    logic [1:0] func;
    logic [1:0] ty;

    rst_n = 1'b0;

    // Directed: empty query, duplicates, a completely full queue, holes, erase
    queue_cmd(FUNC_QUERY, 2'd0, CALL_UP, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd0, CALL_UP, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd0, CALL_DOWN, 1'b0);   // head floor: dropped whatever the type
    queue_cmd(FUNC_PUSH, 2'd1, CALL_UP, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd1, CALL_DOWN, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd1, CALL_ODD, 1'b0);
    for (int f = 2; f < 4; f++) begin
      queue_cmd(FUNC_PUSH, 2'(f), CALL_UP, 1'b0);
      queue_cmd(FUNC_PUSH, 2'(f), CALL_DOWN, 1'b0);
      queue_cmd(FUNC_PUSH, 2'(f), CALL_ODD, 1'b0);
      queue_cmd(FUNC_PUSH, 2'(f), CALL_CAB, 1'b0);
    end
    queue_cmd(FUNC_CLEAR, 2'd0, CALL_UP, 1'b1);    // head emptied, no compaction
    queue_cmd(FUNC_PUSH, 2'd1, CALL_CAB, 1'b0);    // fills the head hole
    queue_cmd(FUNC_PUSH, 2'd0, CALL_UP, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd0, CALL_DOWN, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd0, CALL_ODD, 1'b0);
    queue_cmd(FUNC_PUSH, 2'd0, CALL_CAB, 1'b0);    // all slots taken
    queue_cmd(FUNC_PUSH, 2'd2, CALL_UP, 1'b0);     // cab entry at that floor: dropped
    queue_cmd(FUNC_CLEAR, 2'd2, CALL_UP, 1'b0);
    queue_cmd(FUNC_CLEAR, 2'd3, CALL_UP, 1'b1);
    queue_cmd(FUNC_QUERY, 2'd3, CALL_ODD, 1'b1);
    queue_cmd(FUNC_ERASE, 2'd0, CALL_UP, 1'b1);
    queue_cmd(FUNC_PUSH, 2'd3, CALL_ODD, 1'b1);
    queue_cmd(FUNC_ERASE, 2'd3, CALL_ODD, 1'b0);

    // Random: push-heavy so the queue fills, clears with and without compaction
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 62) func = FUNC_PUSH;
      else if (r < 84) func = FUNC_CLEAR;
      else if (r < 95) func = FUNC_QUERY;
      else func = FUNC_ERASE;
      ty = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 2)) : CALL_ODD;
      queue_cmd(func, 2'($urandom_range(0, 3)), ty, 1'($urandom_range(0, 1)));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_cmds.size() != 0 || in_if.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && expected_reports.size() == 0) begin
      $display("elevator_order_queue_tb: done, clean");
    end else begin
      $display("elevator_order_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
